// ===== design/stdiv_pkg.sv =====
// Shared types and constants for the signed truncating divider.
`timescale 1ns / 1ps
package stdiv_pkg;

  localparam int WIDTH = 12;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

endpackage

// ===== design/stdiv_if.sv =====
// Request channel interfaces for divider operands and results.
`timescale 1ns / 1ps
interface stdiv_in_if;
  import stdiv_pkg::*;
  logic  valid;
  logic  ready;
  word_t dividend;
  word_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface stdiv_out_if;
  import stdiv_pkg::*;
  logic  valid;
  logic  ready;
  word_t quotient;
  word_t remainder;
  logic  divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink (input valid, input quotient, input remainder,
                input divide_by_zero, output ready);
endinterface

// ===== design/stdiv_dp.sv =====
// Divider datapath: operand magnitudes, restoring step, sign fix-up, result register.
`timescale 1ns / 1ps
module stdiv_dp (
  input  logic              clk,
  input  stdiv_pkg::dp_cmd_t cmd,
  input  stdiv_pkg::word_t  dividend,
  input  stdiv_pkg::word_t  divisor,
  output stdiv_pkg::word_t  quotient,
  output stdiv_pkg::word_t  remainder,
  output logic              divide_by_zero
);
  import stdiv_pkg::*;

  word_t num_r, num_nxt;
  word_t rem_r, rem_nxt;
  word_t den_r, den_nxt;
  logic  na_r, na_nxt;
  logic  nb_r, nb_nxt;
  logic  dz_r, dz_nxt;
  word_t q_out_r, q_out_nxt;
  word_t r_out_r, r_out_nxt;
  logic  dz_out_r, dz_out_nxt;

  word_t          shifted;
  logic [WIDTH:0] trial;

  always_comb begin
    shifted = {rem_r[WIDTH-2:0], num_r[WIDTH-1]};
    trial   = {1'b0, shifted} - {1'b0, den_r};

    num_nxt    = num_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    na_nxt     = na_r;
    nb_nxt     = nb_r;
    dz_nxt     = dz_r;
    q_out_nxt  = q_out_r;
    r_out_nxt  = r_out_r;
    dz_out_nxt = dz_out_r;

    if (cmd.load) begin
      na_nxt  = dividend[WIDTH-1];
      nb_nxt  = divisor[WIDTH-1];
      num_nxt = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
      den_nxt = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
      dz_nxt  = (divisor == '0);
      rem_nxt = '0;
    end

    if (cmd.step) begin
      if (!trial[WIDTH]) begin
        rem_nxt = trial[WIDTH-1:0];
        num_nxt = {num_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.finish) begin
      dz_out_nxt = dz_r;
      if (dz_r) begin
        q_out_nxt = '0;
        r_out_nxt = '0;
      end else begin
        q_out_nxt = (na_r ^ nb_r) ? (~num_r + 1'b1) : num_r;
        r_out_nxt = na_r ? (~rem_r + 1'b1) : rem_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    na_r     <= na_nxt;
    nb_r     <= nb_nxt;
    dz_r     <= dz_nxt;
    q_out_r  <= q_out_nxt;
    r_out_r  <= r_out_nxt;
    dz_out_r <= dz_out_nxt;
  end

  assign quotient       = q_out_r;
  assign remainder      = r_out_r;
  assign divide_by_zero = dz_out_r;

endmodule

// ===== design/stdiv_ctrl.sv =====
// Divider controller: request handshakes, bit counter and sequencing of the datapath.
`timescale 1ns / 1ps
module stdiv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output stdiv_pkg::dp_cmd_t cmd
);
  import stdiv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   last_bit;

  assign last_bit = (cnt_r == CNT_W'(WIDTH - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_bit) state_nxt = S_FIX;
      end
      S_FIX: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN) && (cnt_r == '0))
    else $error("load did not start the bit loop");

  a_last_bit_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && last_bit |=> (state_r == S_FIX))
    else $error("bit loop overran");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result not presented");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_IDLE) && !out_valid_r)
    else $error("reset did not clear control state");

endmodule

// ===== design/signed_truncating_divider.sv =====
// Steps: load (S_IDLE), restoring loop (S_RUN), sign fix-up to result register (S_FIX).
// A new request is taken only in S_IDLE; the loop yields one quotient bit per cycle.
// The result register lets the next request enter while a result waits to be taken.
// Reset: synchronous active-low rst_n clears the controller and result valid.
// Results: quotient truncated toward zero, remainder signed as the dividend.
// Zero divisor flags divide_by_zero with zero results.
`timescale 1ns / 1ps
module signed_truncating_divider (
  input  logic clk,
  input  logic rst_n,
  stdiv_in_if.sink    in_ch,
  stdiv_out_if.source out_ch
);
  import stdiv_pkg::*;

  dp_cmd_t cmd;

  stdiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  stdiv_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .dividend       (in_ch.dividend),
    .divisor        (in_ch.divisor),
    .quotient       (out_ch.quotient),
    .remainder      (out_ch.remainder),
    .divide_by_zero (out_ch.divide_by_zero)
  );

endmodule
